/* design/pcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump cycle controller package
// Shared widths, register indexes, mode codes and the structs that pass
// configuration, controller state and tick items between the modules.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int TimeW    = 32;
  localparam int TempW    = 12;
  localparam int SecW     = 17;
  localparam int MsPerS   = 1000;
  localparam int MsW      = SecW + 10;
  localparam int CountW   = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;
  localparam int InDataW  = 128;
  localparam int OutDataW = 168;

  // Result field positions within the output data word.
  localparam int OutCyclesLsb = 5;
  localparam int OutUntilLsb  = 101;

  typedef enum logic [1:0] {
    ModeOff    = 2'd0,
    ModeManual = 2'd1,
    ModeAuto   = 2'd2,
    ModeError  = 2'd3
  } pump_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPumpMode    = 3'd0,
    CfgOnThreshold = 3'd1,
    CfgOffThresh   = 3'd2,
    CfgOnSeconds   = 3'd3,
    CfgOffSeconds  = 3'd4,
    CfgFlowTimeout = 3'd5
  } cfg_index_e;

  typedef struct packed {
    pump_mode_e               mode;
    logic signed [TempW-1:0]  on_thr;
    logic signed [TempW-1:0]  off_thr;
    logic [MsW-1:0]           on_ms;
    logic [MsW-1:0]           off_ms;
    logic [MsW-1:0]           tmo_ms;
  } cfg_t;

  typedef struct packed {
    logic              pump_active;
    logic              cycle_running;
    logic              in_on_phase;
    logic [TimeW-1:0]  cycle_start;
    logic [TimeW-1:0]  rest_start;
    logic              rest_start_valid;
    logic [TimeW-1:0]  run_start;
    logic              run_start_valid;
    logic              flow_alarm;
    logic              below_thr;
    logic [CountW-1:0] cycle_count;
    logic [TimeW-1:0]  run_duration;
    logic [TimeW-1:0]  run_stat;
    logic [TimeW-1:0]  rest_stat;
  } state_t;

  typedef struct packed {
    logic                    func;
    logic [TimeW-1:0]        now_ms;
    logic signed [TempW-1:0] temp_first;
    logic                    temp_first_valid;
    logic signed [TempW-1:0] temp_second;
    logic                    temp_second_valid;
    logic                    meter_first_present;
    logic [TimeW-1:0]        pulse_time_first;
    logic                    meter_second_present;
    logic [TimeW-1:0]        pulse_time_second;
  } tick_t;

endpackage

/* design/pcc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump cycle controller tick logic
// Works out the next controller state and the until-switch time for one
// tick from the current state, the configuration and the tick contents.
// ----------------------------------------------------------------------------
module pcc_step (
  input  pcc_pkg::cfg_t              cfg_i,
  input  pcc_pkg::state_t            state_i,
  input  pcc_pkg::tick_t             tick_i,
  output pcc_pkg::state_t            state_o,
  output logic [pcc_pkg::TimeW-1:0]  until_o
);
  import pcc_pkg::*;

  function automatic state_t drive(state_t s, logic on, logic [TimeW-1:0] now);
    state_t r;
    r = s;
    if (s.pump_active != on) begin
      r.pump_active = on;
      if (on) begin
        r.run_start       = now;
        r.run_start_valid = 1'b1;
      end else if (s.run_start_valid) begin
        r.run_duration = now - s.run_start;
      end
    end
    return r;
  endfunction

  function automatic state_t begin_cycle(state_t s, logic [TimeW-1:0] now);
    state_t r;
    r = s;
    r.cycle_start   = now;
    r.cycle_running = 1'b1;
    r.in_on_phase   = 1'b1;
    r = drive(r, 1'b1, now);
    r.flow_alarm  = 1'b0;
    r.cycle_count = r.cycle_count + CountW'(1);
    return r;
  endfunction

  state_t                  st;
  logic [TimeW-1:0]        now;
  logic [TimeW-1:0]        run;
  logic [TimeW-1:0]        last;
  logic [TimeW-1:0]        el;
  logic [TimeW-1:0]        end_ms;
  logic [MsW:0]            cyc_ms;
  logic signed [TempW-1:0] temp;
  logic                    temp_valid;

  assign cyc_ms = {1'b0, cfg_i.on_ms} + {1'b0, cfg_i.off_ms};

  always_comb begin
    st         = state_i;
    now        = tick_i.now_ms;
    temp_valid = tick_i.temp_first_valid | tick_i.temp_second_valid;
    temp       = tick_i.temp_first_valid ? tick_i.temp_first :
                 (tick_i.temp_second_valid ? tick_i.temp_second : '0);
    run        = '0;
    last       = '0;
    el         = '0;
    end_ms     = '0;
    until_o    = '0;

    if (tick_i.func) begin
      if (cfg_i.mode == ModeAuto) begin
        st.cycle_running = 1'b0;
      end
    end else begin
      if ((tick_i.meter_first_present | tick_i.meter_second_present) && st.pump_active) begin
        run = st.run_start_valid ? (now - st.run_start) : '0;
        if (tick_i.meter_first_present) begin
          last = tick_i.pulse_time_first;
        end
        if (tick_i.meter_second_present && (tick_i.pulse_time_second > last)) begin
          last = tick_i.pulse_time_second;
        end
        if ((run >= TimeW'(cfg_i.tmo_ms)) && ((now - last) >= TimeW'(cfg_i.tmo_ms))) begin
          st.flow_alarm = 1'b1;
        end
      end

      if (st.pump_active && st.run_start_valid) begin
        st.run_stat = now - st.run_start;
      end else if (!st.pump_active && st.rest_start_valid) begin
        st.rest_stat = now - st.rest_start;
      end

      case (cfg_i.mode)
        ModeManual: begin
          if (!st.pump_active) begin
            st            = drive(st, 1'b1, now);
            st.flow_alarm = 1'b0;
          end
        end
        ModeAuto: begin
          if (!temp_valid) begin
            st               = drive(st, 1'b0, now);
            st.cycle_running = 1'b0;
            st.in_on_phase   = 1'b0;
          end else begin
            if (temp < cfg_i.on_thr) begin
              st.below_thr = 1'b1;
            end
            if (st.below_thr) begin
              if (!st.cycle_running) begin
                st = begin_cycle(st, now);
              end else begin
                el = now - st.cycle_start;
                if (st.in_on_phase) begin
                  if (el >= TimeW'(cfg_i.on_ms)) begin
                    st.in_on_phase      = 1'b0;
                    st.rest_start       = now;
                    st.rest_start_valid = 1'b1;
                    st                  = drive(st, 1'b0, now);
                  end
                end else if (el >= TimeW'(cyc_ms)) begin
                  st = begin_cycle(st, now);
                end
              end
            end
            if (temp > cfg_i.off_thr) begin
              if (st.pump_active || st.cycle_running) begin
                st               = drive(st, 1'b0, now);
                st.cycle_running = 1'b0;
                st.in_on_phase   = 1'b0;
              end
              st.below_thr = 1'b0;
            end
            if (st.pump_active && st.flow_alarm) begin
              st = drive(st, 1'b0, now);
            end
          end
        end
        default: begin
          st = drive(st, 1'b0, now);
        end
      endcase
    end

    if ((cfg_i.mode == ModeAuto) && st.cycle_running) begin
      el     = now - st.cycle_start;
      end_ms = st.in_on_phase ? TimeW'(cfg_i.on_ms) : TimeW'(cyc_ms);
      until_o = (end_ms > el) ? (end_ms - el) : '0;
    end
    state_o = st;
  end

endmodule

/* design/pump_cycle_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump cycle controller
// Pump drive with temperature hysteresis, on/off phase cycling and a sticky
// flow fault, one tick request in and one status request out.
// ----------------------------------------------------------------------------
// Ticks enter on the s_axis channel: tuser selects an update tick (0) or a
// forced restart of the automatic cycle (1), tdata carries the time, the two
// temperature readings and the two meter pulse times. Each tick yields one
// status request on the m_axis channel.
// A tick is captured in an input register and worked out in one pass into the
// result register, from which its status request is offered on m_axis. One
// tick is taken every cycle; the only limit is the single result register,
// which is refilled in the cycle it is taken.
// When the receiver stalls, the result register holds and the input register
// fills, after which s_axis_tready falls until the result is taken.
// Registers are written through cfg_we_i, cfg_index_i and cfg_data_i, seconds
// being turned into milliseconds as they are written; the user must write them
// only while no tick is in flight, as the block does not enforce it. Reset
// clears the controller state and both pipeline registers and loads defaults.
// ----------------------------------------------------------------------------
module pump_cycle_controller_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // From bit 0: now_ms, temp_first, temp_first_valid, temp_second,
  // temp_second_valid, meter_first_present, pulse_time_first,
  // meter_second_present, pulse_time_second, zero fill.
  input  logic [pcc_pkg::InDataW-1:0]     s_axis_tdata,
  // func.
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // From bit 0: pump_on, flow_fault, below_flag, on_phase, cycle_active,
  // cycles_started, run_time_ms, rest_time_ms, until_switch_ms, last_run_ms,
  // zero fill.
  output logic [pcc_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [pcc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pcc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import pcc_pkg::*;

  tick_t                tick_d;
  tick_t                tick_q;
  logic                 in_valid_q;
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  logic [OutDataW-1:0]  out_data_d;
  logic                 advance;
  state_t               state_q;
  state_t               state_d;
  cfg_t                 cfg_q;
  logic [TimeW-1:0]     until_ms;

  assign tick_d = '{
    func:                 s_axis_tuser,
    now_ms:               s_axis_tdata[31:0],
    temp_first:           s_axis_tdata[43:32],
    temp_first_valid:     s_axis_tdata[44],
    temp_second:          s_axis_tdata[56:45],
    temp_second_valid:    s_axis_tdata[57],
    meter_first_present:  s_axis_tdata[58],
    pulse_time_first:     s_axis_tdata[90:59],
    meter_second_present: s_axis_tdata[91],
    pulse_time_second:    s_axis_tdata[123:92]
  };

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  pcc_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .tick_i  (tick_q),
    .state_o (state_d),
    .until_o (until_ms)
  );

  assign out_data_d = {3'b000, state_d.run_duration, until_ms, state_d.rest_stat,
                       state_d.run_stat, state_d.cycle_count, state_d.cycle_running,
                       state_d.in_on_phase, state_d.below_thr, state_d.flow_alarm,
                       state_d.pump_active};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q <= tick_d;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (cfg_we_i && (cfg_index_i == CfgPumpMode)) begin
      state_q.cycle_running <= 1'b0;
      if (pump_mode_e'(cfg_data_i[1:0]) == ModeOff) begin
        state_q.in_on_phase <= 1'b0;
      end
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= ModeOff;
      cfg_q.on_thr  <= TempW'(400);
      cfg_q.off_thr <= TempW'(450);
      cfg_q.on_ms   <= MsW'(60 * MsPerS);
      cfg_q.off_ms  <= MsW'(60 * MsPerS);
      cfg_q.tmo_ms  <= MsW'(30 * MsPerS);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgPumpMode:    cfg_q.mode    <= pump_mode_e'(cfg_data_i[1:0]);
        CfgOnThreshold: cfg_q.on_thr  <= cfg_data_i[TempW-1:0];
        CfgOffThresh:   cfg_q.off_thr <= cfg_data_i[TempW-1:0];
        CfgOnSeconds:   cfg_q.on_ms   <= MsW'(cfg_data_i) * MsW'(MsPerS);
        CfgOffSeconds:  cfg_q.off_ms  <= MsW'(cfg_data_i) * MsW'(MsPerS);
        CfgFlowTimeout: cfg_q.tmo_ms  <= MsW'(cfg_data_i) * MsW'(MsPerS);
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* design/pcc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump cycle controller port checker
// Checks the status requests seen on the output channel over time.
// ----------------------------------------------------------------------------
module pcc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [pcc_pkg::OutDataW-1:0]  m_axis_tdata
);
  import pcc_pkg::*;

  logic [CountW-1:0] cycles;
  logic [TimeW-1:0]  until_ms;

  assign cycles   = m_axis_tdata[OutCyclesLsb +: CountW];
  assign until_ms = m_axis_tdata[OutUntilLsb +: TimeW];

  // A stalled request keeps its contents.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled status request changed");

  // A running cycle can only have been started below the on threshold.
  a_cycle_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[2])
    else $error("cycle active without below flag");

  // Time to the next phase change is only reported for a running cycle.
  a_until_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (until_ms != '0)) |-> m_axis_tdata[4])
    else $error("until time without running cycle");

  // One tick starts at most one cycle.
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) ##1 m_axis_tvalid |->
    ((cycles == $past(cycles)) || (cycles == $past(cycles) + CountW'(1))))
    else $error("cycle count jumped between consecutive requests");

endmodule

bind pump_cycle_controller_top pcc_checker u_pcc_checker (.*);

/* bench/pump_status_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump status checker
// Watches the tick, status and register write ports of the pump cycle
// controller, predicts the status for every accepted tick from its own copy
// of the controller state and compares each status request field by field.
// ----------------------------------------------------------------------------
module pump_status_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [pcc_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [pcc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [pcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pcc_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import pcc_pkg::*;

  typedef struct packed {
    logic [TimeW-1:0]  last_run_ms;
    logic [TimeW-1:0]  until_switch_ms;
    logic [TimeW-1:0]  rest_time_ms;
    logic [TimeW-1:0]  run_time_ms;
    logic [CountW-1:0] cycles_started;
    logic              cycle_active;
    logic              on_phase;
    logic              below_flag;
    logic              flow_fault;
    logic              pump_on;
  } status_t;

  state_t                  st;
  pump_mode_e              mode_q;
  logic signed [TempW-1:0] on_thr_q;
  logic signed [TempW-1:0] off_thr_q;
  logic [SecW-1:0]         on_s_q;
  logic [SecW-1:0]         off_s_q;
  logic [SecW-1:0]         tmo_s_q;
  status_t                 expected_q[$];
  status_t                 want;
  status_t                 got;
  int unsigned             fails = 0;

  assign fail_count_o = fails;

  function automatic logic [TimeW-1:0] elapsed(input logic [TimeW-1:0] later,
                                               input logic [TimeW-1:0] earlier);
    return later - earlier;
  endfunction

  function automatic void set_pump(input logic on, input logic [TimeW-1:0] now);
    if (st.pump_active == on) return;
    st.pump_active = on;
    if (on) begin
      st.run_start = now;
      st.run_start_valid = 1'b1;
    end else if (st.run_start_valid) begin
      st.run_duration = elapsed(now, st.run_start);
    end
  endfunction

  function automatic void start_cycle(input logic [TimeW-1:0] now);
    st.cycle_start = now;
    st.cycle_running = 1'b1;
    st.in_on_phase = 1'b1;
    set_pump(1'b1, now);
    st.flow_alarm = 1'b0;
    st.cycle_count = st.cycle_count + 1'b1;
  endfunction

  function automatic void run_auto(input logic [TimeW-1:0] now, input logic temp_ok,
                                   input logic signed [TempW-1:0] temp);
    longint unsigned on_ms;
    longint unsigned cycle_ms;
    longint unsigned el;
    on_ms = on_s_q * MsPerS;
    cycle_ms = on_ms + off_s_q * MsPerS;
    if (!temp_ok) begin
      set_pump(1'b0, now);
      st.cycle_running = 1'b0;
      st.in_on_phase = 1'b0;
      return;
    end
    if (temp < on_thr_q) st.below_thr = 1'b1;
    if (st.below_thr) begin
      if (!st.cycle_running) begin
        start_cycle(now);
      end else begin
        el = elapsed(now, st.cycle_start);
        if (st.in_on_phase) begin
          if (el >= on_ms) begin
            st.in_on_phase = 1'b0;
            st.rest_start = now;
            st.rest_start_valid = 1'b1;
            set_pump(1'b0, now);
          end
        end else if (el >= cycle_ms) begin
          start_cycle(now);
        end
      end
    end
    if (temp > off_thr_q) begin
      if (st.pump_active || st.cycle_running) begin
        set_pump(1'b0, now);
        st.cycle_running = 1'b0;
        st.in_on_phase = 1'b0;
      end
      st.below_thr = 1'b0;
    end
    if (st.pump_active && st.flow_alarm) set_pump(1'b0, now);
  endfunction

  function automatic status_t predict_status(input logic restart, input logic [InDataW-1:0] d);
    logic [TimeW-1:0]        now;
    logic [TimeW-1:0]        p1;
    logic [TimeW-1:0]        p2;
    logic [TimeW-1:0]        newest;
    logic signed [TempW-1:0] t1;
    logic signed [TempW-1:0] t2;
    logic                    v1;
    logic                    v2;
    logic                    m1;
    logic                    m2;
    longint unsigned         on_ms;
    longint unsigned         tmo_ms;
    longint unsigned         run;
    longint unsigned         el;
    longint unsigned         phase_end;
    longint unsigned         remain_ms;
    status_t                 s;
    now = d[31:0];
    t1 = d[43:32];
    v1 = d[44];
    t2 = d[56:45];
    v2 = d[57];
    m1 = d[58];
    p1 = d[90:59];
    m2 = d[91];
    p2 = d[123:92];
    on_ms = on_s_q * MsPerS;
    tmo_ms = tmo_s_q * MsPerS;
    if (restart) begin
      if (mode_q == ModeAuto) st.cycle_running = 1'b0;
    end else begin
      if ((m1 || m2) && st.pump_active) begin
        newest = '0;
        run = st.run_start_valid ? elapsed(now, st.run_start) : 0;
        if (m1 && p1 > newest) newest = p1;
        if (m2 && p2 > newest) newest = p2;
        if (run >= tmo_ms && elapsed(now, newest) >= tmo_ms) st.flow_alarm = 1'b1;
      end
      if (st.pump_active && st.run_start_valid) begin
        st.run_stat = elapsed(now, st.run_start);
      end else if (!st.pump_active && st.rest_start_valid) begin
        st.rest_stat = elapsed(now, st.rest_start);
      end
      case (mode_q)
        ModeManual: begin
          if (!st.pump_active) begin
            set_pump(1'b1, now);
            st.flow_alarm = 1'b0;
          end
        end
        ModeAuto: run_auto(now, v1 | v2, v1 ? t1 : t2);
        default: set_pump(1'b0, now);
      endcase
    end
    remain_ms = 0;
    if (mode_q == ModeAuto && st.cycle_running) begin
      el = elapsed(now, st.cycle_start);
      phase_end = st.in_on_phase ? on_ms : on_ms + off_s_q * MsPerS;
      remain_ms = phase_end > el ? phase_end - el : 0;
    end
    s.pump_on = st.pump_active;
    s.flow_fault = st.flow_alarm;
    s.below_flag = st.below_thr;
    s.on_phase = st.in_on_phase;
    s.cycle_active = st.cycle_running;
    s.cycles_started = st.cycle_count;
    s.run_time_ms = st.run_stat;
    s.rest_time_ms = st.rest_stat;
    s.until_switch_ms = remain_ms[TimeW-1:0];
    s.last_run_ms = st.run_duration;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st = '0;
      mode_q = ModeOff;
      on_thr_q = 12'sd400;
      off_thr_q = 12'sd450;
      on_s_q = 17'd60;
      off_s_q = 17'd60;
      tmo_s_q = 17'd30;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CfgPumpMode: begin
            mode_q = pump_mode_e'(cfg_data_i[1:0]);
            st.cycle_running = 1'b0;
            if (mode_q == ModeOff) st.in_on_phase = 1'b0;
          end
          CfgOnThreshold: on_thr_q = cfg_data_i[TempW-1:0];
          CfgOffThresh: off_thr_q = cfg_data_i[TempW-1:0];
          CfgOnSeconds: on_s_q = cfg_data_i[SecW-1:0];
          CfgOffSeconds: off_s_q = cfg_data_i[SecW-1:0];
          CfgFlowTimeout: tmo_s_q = cfg_data_i[SecW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_status(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("Status request arrived with no tick outstanding.");
          fails++;
        end else begin
          want = expected_q.pop_front();
          got = status_t'(m_axis_tdata[$bits(status_t)-1:0]);
          check_field("pump_on", want.pump_on, got.pump_on);
          check_field("flow_fault", want.flow_fault, got.flow_fault);
          check_field("below_flag", want.below_flag, got.below_flag);
          check_field("on_phase", want.on_phase, got.on_phase);
          check_field("cycle_active", want.cycle_active, got.cycle_active);
          check_field("cycles_started", want.cycles_started, got.cycles_started);
          check_field("run_time_ms", want.run_time_ms, got.run_time_ms);
          check_field("rest_time_ms", want.rest_time_ms, got.rest_time_ms);
          check_field("until_switch_ms", want.until_switch_ms, got.until_switch_ms);
          check_field("last_run_ms", want.last_run_ms, got.last_run_ms);
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

/* bench/pump_cycle_controller_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pump cycle controller testbench
// Drives tick requests and register writes into the controller: a directed
// run over the field extremes, the threshold edges, restarts, sensor fallback
// and time wrap, then random ticks under a series of register settings with
// random stalls on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module pump_cycle_controller_top_tb;
  import pcc_pkg::*;

  localparam int TicksPerSetting = 53;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned      fail_count;
  int unsigned      pending_count;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  int unsigned      span_ms = 1000;
  int unsigned      tmo_ms = 1;
  int               on_thr_v = 400;
  int               off_thr_v = 450;
  logic [TimeW-1:0] now_acc = '0;

  pump_cycle_controller_top DUT (.*);

  pump_status_check status_check (
    .fail_count_o(fail_count),
    .pending_o   (pending_count),
    .*
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("pump_cycle_controller_top_tb: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_tick(input logic restart, input logic [TimeW-1:0] now,
                           input logic signed [TempW-1:0] t1, input logic v1,
                           input logic signed [TempW-1:0] t2, input logic v2,
                           input logic m1, input logic [TimeW-1:0] p1,
                           input logic m2, input logic [TimeW-1:0] p2);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= restart;
    s_axis_tdata <= {4'b0, p2, m2, p1, m1, v2, t2, v1, t1, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input pump_mode_e mode, input int on_thr, input int off_thr,
                               input int on_s, input int off_s, input int tmo_s);
    settle();
    write_reg(CfgPumpMode, CfgDataW'(mode));
    write_reg(CfgOnThreshold, CfgDataW'(on_thr));
    write_reg(CfgOffThresh, CfgDataW'(off_thr));
    write_reg(CfgOnSeconds, CfgDataW'(on_s));
    write_reg(CfgOffSeconds, CfgDataW'(off_s));
    write_reg(CfgFlowTimeout, CfgDataW'(tmo_s));
    cfg_we_i <= 1'b0;
    on_thr_v = on_thr;
    off_thr_v = off_thr;
    span_ms = (on_s + off_s) * 1000 + 1000;
    tmo_ms = tmo_s * 1000 + 1;
  endtask

  function automatic logic signed [TempW-1:0] pick_temp();
    int v;
    case ($urandom_range(4, 0))
      0: v = int'($urandom_range(3000, 0)) - 1000;
      1, 2: v = on_thr_v + int'($urandom_range(60, 0)) - 30;
      default: v = off_thr_v + int'($urandom_range(60, 0)) - 30;
    endcase
    if (v < -1000) v = -1000;
    if (v > 2000) v = 2000;
    return TempW'(v);
  endfunction

  function automatic logic [TimeW-1:0] pick_pulse();
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return now_acc + $urandom_range(2000, 0);
      default: return now_acc - $urandom_range(2 * tmo_ms, 0);
    endcase
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(39, 0) == 0) settle();
      case ($urandom_range(19, 0))
        0: now_acc = $urandom();
        1: ;
        default: now_acc = now_acc + $urandom_range(span_ms / 3, 0);
      endcase
      send_tick($urandom_range(19, 0) == 0, now_acc,
                pick_temp(), $urandom_range(9, 0) < 8,
                pick_temp(), $urandom_range(9, 0) < 7,
                $urandom_range(9, 0) < 6, pick_pulse(),
                $urandom_range(9, 0) < 6, pick_pulse());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_setting(ModeAuto, 400, 450, 1, 1, 1);
    send_tick(1'b0, 32'd0, 12'sd300, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'd500, -12'sd1000, 1'b1, 12'sd2000, 1'b1, 1'b1, '0, 1'b0, '0);
    send_tick(1'b0, 32'd1200, 12'sd300, 1'b1, 12'sd0, 1'b0, 1'b1, '0, 1'b0, '0);
    send_tick(1'b0, 32'd2500, 12'sd300, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b1, 32'd2600, 12'sd300, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'd2700, 12'sd2000, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'd2800, 12'sd2000, 1'b0, 12'sd300, 1'b1, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'd2900, 12'sd0, 1'b0, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'd3000, 12'sd400, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'd3100, 12'sd450, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'd3200, 12'sd399, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'd3300, 12'sd451, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'hFFFF_FC00, 12'sd300, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);
    send_tick(1'b0, 32'h0000_0100, 12'sd300, 1'b1, 12'sd0, 1'b0, 1'b0, '0,
              1'b1, 32'hFFFF_FFFF);
    send_tick(1'b0, 32'hFFFF_FFFF, -12'sd1000, 1'b0, -12'sd1000, 1'b1,
              1'b1, 32'hFFFF_FFFF, 1'b1, '0);
    send_tick(1'b1, 32'hFFFF_FFFF, 12'sd300, 1'b1, 12'sd0, 1'b0, 1'b0, '0, 1'b0, '0);

    tx_idle_pct = 27;
    rx_idle_pct = 54;
    apply_setting(ModeAuto, 400, 450, 2, 1, 1);
    now_acc = 32'hFFFF_F000;
    run_random(TicksPerSetting);
    apply_setting(ModeManual, 400, 450, 60, 60, 3);
    run_random(TicksPerSetting);
    apply_setting(ModeOff, 100, 200, 5, 5, 5);
    run_random(TicksPerSetting);
    apply_setting(ModeAuto, -1000, 2000, 0, 0, 0);
    run_random(TicksPerSetting);

    tx_idle_pct = 54;
    rx_idle_pct = 27;
    apply_setting(ModeAuto, 2000, -1000, 1, 2, 2);
    run_random(TicksPerSetting);
    apply_setting(ModeManual, 0, 0, 1, 1, 0);
    run_random(TicksPerSetting);
    apply_setting(ModeError, 400, 450, 3, 3, 1);
    run_random(TicksPerSetting);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_setting(ModeAuto, 600, 700, 86400, 86400, 86400);
    run_random(TicksPerSetting);
    apply_setting(ModeAuto, 450, 450, 131071, 1, 131071);
    run_random(TicksPerSetting);
    apply_setting(ModeAuto, 300, 500, 3, 2, 2);
    run_random(TicksPerSetting);

    settle();
    if (fail_count == 0) begin
      $display("pump_cycle_controller_top_tb: PASS");
    end else begin
      $display("pump_cycle_controller_top_tb: FAIL");
    end
    $finish;
  end

endmodule
